/* src/cbpe_pkg.sv */
// cbpe_pkg: shared widths, register codes and pipeline stage numbering
// for the cubic bezier point evaluator; no dependencies
package cbpe_pkg;

    // fixed field widths
    localparam int CTRL_W    = 9;
    localparam int IDX_W     = 14;
    localparam int OUT_W     = 17;
    localparam int CFG_IDX_W = 3;

    // largest legal coordinate out: 511 pixels with 8 fraction bits
    localparam logic [OUT_W-1:0] POINT_MAX = 17'd130816;

    // pipeline stages, in order
    localparam int ST_CLAMP   = 0;
    localparam int ST_SQUARE  = 1;
    localparam int ST_WEIGHT  = 2;
    localparam int ST_SCALE   = 3;
    localparam int ST_SUM     = 4;
    localparam int ST_ROUND   = 5;
    localparam int NUM_STAGES = 6;

    // one advance enable per stage
    typedef logic [NUM_STAGES-1:0] cbpe_adv_t;

    // configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CTRL0_X,
        REG_CTRL0_Y,
        REG_CTRL1_X,
        REG_CTRL1_Y,
        REG_CTRL2_X,
        REG_CTRL2_Y,
        REG_CTRL3_X,
        REG_CTRL3_Y
    } cbpe_reg_t;

endpackage

/* src/cubic_bezier_point_eval.sv */
// cubic_bezier_point_eval: top level, configuration registers, pipeline
// valid/enable control; depends on cbpe_pkg, cbpe_weight, cbpe_blend
//
// Evaluates B(t) = (1-t)^3 P0 + 3t(1-t)^2 P1 + 3t^2(1-t) P2 + t^3 P3 for
// t = param_index / D, where D is STEP_COUNT (a power of two; otherwise the
// largest power of two below it). An index above D is taken as D, giving P3.
// The four control points are whole-pixel coordinates written through the
// cfg port (index 0..7: ctrl0_x, ctrl0_y, ... ctrl3_y, all reset to 0); write
// them only while no word is in flight. point_x and point_y come out in
// unsigned fixed point with 8 fraction bits, rounded to nearest, ties up.
// Throughput is one word per clock while out_ready is high. A word is
// registered in each stage in turn, and out_valid rises when it reaches
// the last stage of the six-stage pipeline (clamp, square, weight,
// scale by control point, sum, round). Each stage has its own valid bit and
// only holds when it is full and the stage after it is holding, so bubbles
// close up under back-pressure and in_ready drops only when all six stages
// are full and out_ready is low.
module cubic_bezier_point_eval #(
    parameter int STEP_COUNT = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbpe_pkg::CTRL_W-1:0]         cfg_data,
    // parameter index in
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cbpe_pkg::IDX_W-1:0]          param_index,
    // curve point out
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cbpe_pkg::OUT_W-1:0]          point_x,
    output logic [cbpe_pkg::OUT_W-1:0]          point_y
);

    localparam int WW = 3 * $clog2(STEP_COUNT + 1);

    logic [3:0][cbpe_pkg::CTRL_W-1:0]   ctrl_x_reg;
    logic [3:0][cbpe_pkg::CTRL_W-1:0]   ctrl_y_reg;
    logic [cbpe_pkg::NUM_STAGES-1:0]    valid_reg;
    logic [cbpe_pkg::NUM_STAGES-1:0]    valid_next;
    cbpe_pkg::cbpe_adv_t                adv;
    logic [3:0][WW-1:0]                 weight;
    logic                               in_fire;
    logic                               out_fire;

    // ------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_x_reg <= '0;
            ctrl_y_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cbpe_pkg::cbpe_reg_t'(cfg_index))
                cbpe_pkg::REG_CTRL0_X: ctrl_x_reg[0] <= cfg_data;
                cbpe_pkg::REG_CTRL0_Y: ctrl_y_reg[0] <= cfg_data;
                cbpe_pkg::REG_CTRL1_X: ctrl_x_reg[1] <= cfg_data;
                cbpe_pkg::REG_CTRL1_Y: ctrl_y_reg[1] <= cfg_data;
                cbpe_pkg::REG_CTRL2_X: ctrl_x_reg[2] <= cfg_data;
                cbpe_pkg::REG_CTRL2_Y: ctrl_y_reg[2] <= cfg_data;
                cbpe_pkg::REG_CTRL3_X: ctrl_x_reg[3] <= cfg_data;
                cbpe_pkg::REG_CTRL3_Y: ctrl_y_reg[3] <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage enables: a stage moves when it is empty or the next one moves
    // ------------------------------------------------------------------
    always_comb
    begin
        adv[cbpe_pkg::NUM_STAGES-1] = !valid_reg[cbpe_pkg::NUM_STAGES-1] || out_ready;
        for (int k = cbpe_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[cbpe_pkg::ST_CLAMP];
    assign in_fire   = in_valid && in_ready;
    assign out_valid = valid_reg[cbpe_pkg::NUM_STAGES-1];
    assign out_fire  = out_valid && out_ready;

    // valid bits travel with the word
    always_comb
    begin
        valid_next = valid_reg;
        if (adv[cbpe_pkg::ST_CLAMP])
        begin
            valid_next[cbpe_pkg::ST_CLAMP] = in_valid;
        end
        for (int k = 1; k < cbpe_pkg::NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // datapath: shared weights, one blend per coordinate
    // ------------------------------------------------------------------
    cbpe_weight #(
        .STEP_COUNT (STEP_COUNT)
    ) u_weight (
        .clk         (clk),
        .adv         (adv),
        .param_index (param_index),
        .weight      (weight)
    );

    cbpe_blend #(
        .STEP_COUNT (STEP_COUNT)
    ) u_blend_x (
        .clk    (clk),
        .adv    (adv),
        .weight (weight),
        .ctrl   (ctrl_x_reg),
        .point  (point_x)
    );

    cbpe_blend #(
        .STEP_COUNT (STEP_COUNT)
    ) u_blend_y (
        .clk    (clk),
        .adv    (adv),
        .weight (weight),
        .ctrl   (ctrl_y_reg),
        .point  (point_y)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // input only backs up when the whole pipe is full and output is stalled
    a_ready_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (valid_reg == '1) && !out_ready
    ) else $error("in_ready low while pipeline has room");

    // an empty pipe always takes a word
    a_empty_takes_word: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |-> in_ready
    ) else $error("empty pipeline not ready");

    // words in flight change only by accepted inputs and outputs
    a_occupancy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            ($countones(valid_reg) == $past($countones(valid_reg))
                + $past(int'(in_fire)) - $past(int'(out_fire)))
    ) else $error("word lost or duplicated in pipeline");

    // a blend of in-range pixels cannot leave the pixel range
    a_point_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (point_x <= cbpe_pkg::POINT_MAX) && (point_y <= cbpe_pkg::POINT_MAX)
    ) else $error("point outside control point range");

endmodule

/* src/cbpe_weight.sv */
// cbpe_weight: first three stages, clamps the index and forms the four
// bernstein weights scaled by D^3; depends on cbpe_pkg
module cbpe_weight #(
    parameter int STEP_COUNT = 8192
) (
    input  logic                                     clk,
    input  cbpe_pkg::cbpe_adv_t                      adv,
    input  logic [cbpe_pkg::IDX_W-1:0]               param_index,
    output logic [3:0][3*$clog2(STEP_COUNT+1)-1:0]   weight
);

    localparam int LOG_D = $clog2(STEP_COUNT + 1) - 1;
    localparam int W     = LOG_D + 1;
    localparam int WW    = 3 * W;
    localparam int CW    = (cbpe_pkg::IDX_W > W) ? cbpe_pkg::IDX_W : W;
    localparam logic [CW-1:0] D_CW = CW'(1) << LOG_D;
    localparam logic [W-1:0]  D_W  = W'(1) << LOG_D;

    logic [CW-1:0]       idx_ext;
    logic [W-1:0]        idx_sat;
    logic [W-1:0]        t1_reg;
    logic [W-1:0]        u1_reg;
    logic [W-1:0]        t2_reg;
    logic [W-1:0]        u2_reg;
    logic [2*W-1:0]      tt_reg;
    logic [2*W-1:0]      uu_reg;
    logic [WW-1:0]       uut;
    logic [WW-1:0]       ttu;
    logic [3:0][WW-1:0]  weight_reg;

    // index past the end behaves as t = 1
    assign idx_ext = CW'(param_index);
    assign idx_sat = (idx_ext > D_CW) ? D_W : idx_ext[W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[cbpe_pkg::ST_CLAMP])
        begin
            t1_reg <= idx_sat;
            u1_reg <= D_W - idx_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[cbpe_pkg::ST_SQUARE])
        begin
            t2_reg <= t1_reg;
            u2_reg <= u1_reg;
            tt_reg <= (2*W)'(t1_reg) * (2*W)'(t1_reg);
            uu_reg <= (2*W)'(u1_reg) * (2*W)'(u1_reg);
        end
    end

    assign uut = WW'(uu_reg) * WW'(t2_reg);
    assign ttu = WW'(tt_reg) * WW'(u2_reg);

    always_ff @(posedge clk)
    begin
        if (adv[cbpe_pkg::ST_WEIGHT])
        begin
            weight_reg[0] <= WW'(uu_reg) * WW'(u2_reg);
            weight_reg[1] <= (uut << 1) + uut;
            weight_reg[2] <= (ttu << 1) + ttu;
            weight_reg[3] <= WW'(tt_reg) * WW'(t2_reg);
        end
    end

    assign weight = weight_reg;

endmodule

/* src/cbpe_blend.sv */
// cbpe_blend: last three stages for one coordinate, weights times control
// points, sum, then round to 8 fraction bits; depends on cbpe_pkg
module cbpe_blend #(
    parameter int STEP_COUNT = 8192
) (
    input  logic                                     clk,
    input  cbpe_pkg::cbpe_adv_t                      adv,
    input  logic [3:0][3*$clog2(STEP_COUNT+1)-1:0]   weight,
    input  logic [3:0][cbpe_pkg::CTRL_W-1:0]         ctrl,
    output logic [cbpe_pkg::OUT_W-1:0]               point
);

    localparam int LOG_D = $clog2(STEP_COUNT + 1) - 1;
    localparam int WW    = 3 * (LOG_D + 1);
    localparam int PW    = WW + cbpe_pkg::CTRL_W;
    localparam int SHIFT = 3 * LOG_D - 8;

    logic [3:0][PW-1:0]             prod_reg;
    logic [PW-1:0]                  sum_reg;
    logic [cbpe_pkg::OUT_W-1:0]     rounded;
    logic [cbpe_pkg::OUT_W-1:0]     point_reg;

    always_ff @(posedge clk)
    begin
        if (adv[cbpe_pkg::ST_SCALE])
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= PW'(weight[k]) * PW'(ctrl[k]);
            end
        end
    end

    // weights add up to D^3, so the sum stays below 512 * D^3
    always_ff @(posedge clk)
    begin
        if (adv[cbpe_pkg::ST_SUM])
        begin
            sum_reg <= prod_reg[0] + prod_reg[1] + prod_reg[2] + prod_reg[3];
        end
    end

    generate
        if (SHIFT > 0)
        begin : g_round_down
            // round half up, then drop SHIFT bits
            logic [PW:0] biased;
            assign biased  = {1'b0, sum_reg} + ((PW+1)'(1) << (SHIFT - 1));
            assign rounded = biased[SHIFT +: cbpe_pkg::OUT_W];
        end
        else
        begin : g_scale_up
            logic [PW+7:0] scaled;
            assign scaled  = (PW+8)'(sum_reg) << (-SHIFT);
            assign rounded = scaled[cbpe_pkg::OUT_W-1:0];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv[cbpe_pkg::ST_ROUND])
        begin
            point_reg <= rounded;
        end
    end

    assign point = point_reg;

endmodule

/* test/cbpe_point_checker.sv */
// cbpe_point_checker: watches the cfg, input and output channels of the
// cubic bezier point evaluator, predicts each point and compares it
// depends on cbpe_pkg
`timescale 1ns / 1ps

module cbpe_point_checker #(
    parameter int STEP_COUNT = 8192
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [cbpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbpe_pkg::CTRL_W-1:0]    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [cbpe_pkg::IDX_W-1:0]     param_index,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [cbpe_pkg::OUT_W-1:0]     point_x,
    input  logic [cbpe_pkg::OUT_W-1:0]     point_y,
    output int                             mismatch_count,
    output int                             points_in_flight
);

    // divisor is the largest power of two not above STEP_COUNT
    localparam int          STEP_LOG2   = $clog2(STEP_COUNT + 1) - 1;
    localparam logic [63:0] DIVISOR     = 64'd1 << STEP_LOG2;
    localparam int          SCALE_SHIFT = 3 * STEP_LOG2 - 8;
    localparam int          FIFO_DEPTH  = 64;

    typedef struct packed {
        logic [cbpe_pkg::OUT_W-1:0] x;
        logic [cbpe_pkg::OUT_W-1:0] y;
        logic [cbpe_pkg::IDX_W-1:0] index;
    } point_word_t;

    // expected points in order of acceptance, kept as a ring
    point_word_t                 expected_buf [FIFO_DEPTH];
    int                          rd_ptr;
    int                          wr_ptr;
    int                          pending;
    logic [cbpe_pkg::CTRL_W-1:0] ctrl_pts [8];
    int                          err_total;

    // exact bernstein sum, then scaled by 256 / D^3 with round half up
    function automatic logic [cbpe_pkg::OUT_W-1:0] bezier_axis(
        input logic [cbpe_pkg::CTRL_W-1:0] p0,
        input logic [cbpe_pkg::CTRL_W-1:0] p1,
        input logic [cbpe_pkg::CTRL_W-1:0] p2,
        input logic [cbpe_pkg::CTRL_W-1:0] p3,
        input logic [63:0]                 t_num
    );
        logic [63:0] u_num;
        logic [63:0] weighted_sum;
        logic [63:0] scaled;
        int          amount;
        u_num        = DIVISOR - t_num;
        weighted_sum = 64'(p0) * u_num * u_num * u_num
                     + 64'd3 * 64'(p1) * t_num * u_num * u_num
                     + 64'd3 * 64'(p2) * t_num * t_num * u_num
                     + 64'(p3) * t_num * t_num * t_num;
        if (SCALE_SHIFT <= 0)
        begin
            amount = -SCALE_SHIFT;
            scaled = weighted_sum << amount;
        end
        else
        begin
            amount = SCALE_SHIFT;
            scaled = (weighted_sum + (64'd1 << (amount - 1))) >> amount;
        end
        return scaled[cbpe_pkg::OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        point_word_t want;
        logic [63:0] t_num;
        if (!rst_n)
        begin
            for (int n = 0; n < 8; n++)
                ctrl_pts[n] = '0;
            rd_ptr    = 0;
            wr_ptr    = 0;
            pending   = 0;
            err_total = 0;
            mismatch_count   <= 0;
            points_in_flight <= 0;
        end
        else
        begin
            // results first, so a word accepted this edge is never matched
            if (out_valid && out_ready)
            begin
                if (pending == 0)
                begin
                    $display("%0t: unexpected point x=%0d y=%0d", $time, point_x, point_y);
                    err_total++;
                end
                else
                begin
                    want    = expected_buf[rd_ptr];
                    rd_ptr  = (rd_ptr + 1) % FIFO_DEPTH;
                    pending = pending - 1;
                    if (point_x !== want.x)
                    begin
                        $display("%0t: point_x mismatch index=%0d expected=%0d actual=%0d",
                                 $time, want.index, want.x, point_x);
                        err_total++;
                    end
                    if (point_y !== want.y)
                    begin
                        $display("%0t: point_y mismatch index=%0d expected=%0d actual=%0d",
                                 $time, want.index, want.y, point_y);
                        err_total++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                t_num = 64'(param_index);
                if (t_num > DIVISOR)
                    t_num = DIVISOR;
                want.index = param_index;
                want.x = bezier_axis(ctrl_pts[cbpe_pkg::REG_CTRL0_X],
                                     ctrl_pts[cbpe_pkg::REG_CTRL1_X],
                                     ctrl_pts[cbpe_pkg::REG_CTRL2_X],
                                     ctrl_pts[cbpe_pkg::REG_CTRL3_X], t_num);
                want.y = bezier_axis(ctrl_pts[cbpe_pkg::REG_CTRL0_Y],
                                     ctrl_pts[cbpe_pkg::REG_CTRL1_Y],
                                     ctrl_pts[cbpe_pkg::REG_CTRL2_Y],
                                     ctrl_pts[cbpe_pkg::REG_CTRL3_Y], t_num);
                if (pending == FIFO_DEPTH)
                begin
                    $display("%0t: too many points in flight, index=%0d", $time, param_index);
                    err_total++;
                end
                else
                begin
                    expected_buf[wr_ptr] = want;
                    wr_ptr  = (wr_ptr + 1) % FIFO_DEPTH;
                    pending = pending + 1;
                end
            end
            if (cfg_valid && cfg_ready)
                ctrl_pts[cfg_index] = cfg_data;
            mismatch_count   <= err_total;
            points_in_flight <= pending;
        end
    end

endmodule

/* test/tb_cubic_bezier_point_eval.sv */
// tb_cubic_bezier_point_eval: stimulus and verdict for the cubic bezier
// point evaluator; depends on cbpe_pkg, cubic_bezier_point_eval and
// cbpe_point_checker
`timescale 1ns / 1ps

module tb_cubic_bezier_point_eval;

    localparam int STEP_COUNT  = 8192;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_WORDS = 255;
    localparam int IDX_W       = cbpe_pkg::IDX_W;
    localparam int CTRL_W      = cbpe_pkg::CTRL_W;
    localparam int OUT_W       = cbpe_pkg::OUT_W;
    localparam int CFG_IDX_W   = cbpe_pkg::CFG_IDX_W;
    localparam int IDX_MAX     = (1 << IDX_W) - 1;
    localparam int CTRL_MAX    = (1 << CTRL_W) - 1;

    // receiver stall patterns
    typedef enum {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CTRL_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [IDX_W-1:0]     param_index;
    logic                 out_valid;
    logic                 out_ready;
    logic [OUT_W-1:0]     point_x;
    logic [OUT_W-1:0]     point_y;

    int mismatch_count;
    int points_in_flight;

    // control points staged for the next configuration pass
    logic [CTRL_W-1:0] ctrl_next [8];

    // sender burst shaping
    int burst_left;
    int gap_max;
    bit gaps_off;

    // set by the stimulus, cleared by the receiver once its hold-off is over
    bit hold_req;

    cubic_bezier_point_eval #(
        .STEP_COUNT(STEP_COUNT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .param_index(param_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_x    (point_x),
        .point_y    (point_y)
    );

    cbpe_point_checker #(
        .STEP_COUNT(STEP_COUNT)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .param_index     (param_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .point_x         (point_x),
        .point_y         (point_y),
        .mismatch_count  (mismatch_count),
        .points_in_flight(points_in_flight)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // coordinate with a strong bias toward both ends of the range
    function automatic int pick_coord();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return CTRL_MAX;
            default: return int'($urandom_range(0, CTRL_MAX));
        endcase
    endfunction

    // mostly inside the curve, some past its end, a few boundary indices
    function automatic int pick_index();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0:       return 0;
                    1:       return 1;
                    2:       return STEP_COUNT - 1;
                    3:       return STEP_COUNT;
                    4:       return STEP_COUNT + 1;
                    default: return IDX_MAX;
                endcase
            end
            1, 2:    return int'($urandom_range(0, IDX_MAX));
            default: return int'($urandom_range(0, STEP_COUNT));
        endcase
    endfunction

    // offer one word and hold it until accepted; in_ready is sampled at the
    // falling edge so the accepting rising edge is known without a race
    task automatic send_index(input int idx);
        bit hit;
        in_valid    <= 1'b1;
        param_index <= IDX_W'(idx);
        hit = 1'b0;
        while (!hit)
        begin
            @(negedge clk);
            hit = in_ready;
            @(posedge clk);
        end
        if (gaps_off || burst_left > 0)
        begin
            if (burst_left > 0)
                burst_left--;
        end
        else
        begin
            // end of burst: idle for a while, then pick the next burst length
            in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : int'($urandom_range(0, 24));
        end
    endtask

    // stop offering and wait until every predicted point has come out
    task automatic drain_points();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (points_in_flight == 0);
        @(posedge clk);
    endtask

    // write all eight control coordinates back to back, pipeline idle
    task automatic load_points();
        cbpe_pkg::cbpe_reg_t reg_code;
        bit                  hit;
        reg_code = reg_code.first();
        repeat (reg_code.num())
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_code;
            cfg_data  <= ctrl_next[reg_code];
            hit = 1'b0;
            while (!hit)
            begin
                @(negedge clk);
                hit = cfg_ready;
                @(posedge clk);
            end
            reg_code = reg_code.next();
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_points(input int x0, input int y0,
                              input int x1, input int y1,
                              input int x2, input int y2,
                              input int x3, input int y3);
        ctrl_next[cbpe_pkg::REG_CTRL0_X] = CTRL_W'(x0);
        ctrl_next[cbpe_pkg::REG_CTRL0_Y] = CTRL_W'(y0);
        ctrl_next[cbpe_pkg::REG_CTRL1_X] = CTRL_W'(x1);
        ctrl_next[cbpe_pkg::REG_CTRL1_Y] = CTRL_W'(y1);
        ctrl_next[cbpe_pkg::REG_CTRL2_X] = CTRL_W'(x2);
        ctrl_next[cbpe_pkg::REG_CTRL2_Y] = CTRL_W'(y2);
        ctrl_next[cbpe_pkg::REG_CTRL3_X] = CTRL_W'(x3);
        ctrl_next[cbpe_pkg::REG_CTRL3_Y] = CTRL_W'(y3);
        load_points();
    endtask

    // receiver: stall patterns, each held for a random run before the next is
    // picked, plus one long hold-off on request
    initial
    begin : receiver
        rx_mode_t   mode;
        int         mode_left;
        logic [7:0] ready_pat;
        out_ready = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        ready_pat = 8'hff;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // long hold-off so all six stages fill and in_ready drops
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = int'($urandom_range(20, 300));
                    ready_pat = 8'($urandom_range(1, 255));
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
                    default:
                    begin
                        out_ready <= ready_pat[0];
                        ready_pat = {ready_pat[0], ready_pat[7:1]};
                    end
                endcase
            end
        end
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        param_index = '0;
        hold_req    = 1'b0;
        gaps_off    = 1'b0;
        burst_left  = 4;
        gap_max     = 6;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset control points are all zero: every point is the origin
        send_index(0);
        send_index(STEP_COUNT);
        send_index(IDX_MAX);
        send_index(STEP_COUNT / 2);
        drain_points();

        // all coordinates at their maximum, both ends of t and past the end
        set_points(CTRL_MAX, CTRL_MAX, CTRL_MAX, CTRL_MAX,
                   CTRL_MAX, CTRL_MAX, CTRL_MAX, CTRL_MAX);
        send_index(0);
        send_index(1);
        send_index(STEP_COUNT / 2);
        send_index(STEP_COUNT - 1);
        send_index(STEP_COUNT);
        send_index(STEP_COUNT + 1);
        send_index(IDX_MAX);
        drain_points();

        // zigzag between the extremes so every bernstein term matters
        set_points(0, CTRL_MAX, CTRL_MAX, 0, 0, CTRL_MAX, CTRL_MAX, 0);
        send_index(0);
        send_index(1);
        send_index(2);
        send_index(STEP_COUNT / 4);
        send_index(STEP_COUNT / 2);
        send_index(3 * STEP_COUNT / 4);
        send_index(STEP_COUNT - 1);
        send_index(STEP_COUNT);
        send_index('h1555);
        send_index('h2aaa);
        send_index(STEP_COUNT + STEP_COUNT / 3);
        drain_points();

        // random control points per phase, random indices within
        for (int phase = 0; phase < 6; phase++)
        begin
            set_points(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                       pick_coord(), pick_coord(), pick_coord(), pick_coord());
            gap_max = int'($urandom_range(1, 12));
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (phase == 2 && n == 100)
                begin
                    // back-pressure test: receiver holds off, sender keeps offering
                    hold_req = 1'b1;
                    gaps_off = 1'b1;
                end
                if (phase == 2 && n == 160)
                    gaps_off = 1'b0;
                send_index(pick_index());
            end
            drain_points();
        end

        // settle, then look for stray results
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && points_in_flight == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
